@@ src/rss_pkg.sv @@
// Types, codes and fixed tables shared by the recirculating shower sequencer.
package rss_pkg;

  // Phase codes, also driven out on the phase field.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRE     = 3'd1,
    PH_SHOWER  = 3'd2,
    PH_LOOP    = 3'd3,
    PH_STOP    = 3'd4,
    PH_AIRGAP  = 3'd5,
    PH_POST    = 3'd6,
    PH_FINAL   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    LIGHT_STEADY = 2'd0,
    LIGHT_DARK   = 2'd1,
    LIGHT_FLASH  = 2'd2
  } light_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LOW_POWER_DELAY   = 3'd0,
    CFG_PREWASH_TIME      = 3'd1,
    CFG_FLOW_STOP_TIME    = 3'd2,
    CFG_AIRGAP_TIME       = 3'd3,
    CFG_POSTWASH_TIME     = 3'd4,
    CFG_FINAL_EMPTY_TIME  = 3'd5,
    CFG_FIRST_LOOP_DELAY  = 3'd6,
    CFG_RESUME_LOOP_DELAY = 3'd7
  } cfg_idx_e;

  localparam int unsigned TimerWidth = 20;
  localparam int unsigned DelayWidth = 10;
  localparam int unsigned PowerWidth = 10;

  localparam logic [TimerWidth-1:0] TimerMax          = '1;
  localparam logic [TimerWidth-1:0] RecentShowerTicks = 20'd0;
  localparam logic [PowerWidth-1:0] FullPower         = 10'd1000;

  // Valve bits: 0 diverter, 1 head drain, 2 delivery drain, 3 loop drain, 4 relay.
  // On entry, bits set in the update mask take the value from the value table.
  localparam logic [4:0] ValveUpd [8] = '{5'h1F, 5'h1F, 5'h1E, 5'h1E,
                                          5'h0E, 5'h0F, 5'h0F, 5'h0F};
  localparam logic [4:0] ValveVal [8] = '{5'h1F, 5'h0D, 5'h02, 5'h02,
                                          5'h02, 5'h0D, 5'h0D, 5'h0F};

  typedef struct packed {
    logic                  head_on;
    logic                  hand_on;
    logic [PowerWidth-1:0] head_power;
    logic [PowerWidth-1:0] hand_power;
    logic                  lamp_feedback;
    logic                  loop_press;
    logic                  emergency;
  } rss_in_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic                  delivery_pump_run;
    logic [PowerWidth-1:0] delivery_pump_level;
    logic                  loop_pump_run;
    logic                  lamp_drive;
    logic                  diverter_open;
    logic                  head_drain_open;
    logic                  delivery_drain_open;
    logic                  loop_drain_open;
    logic                  relay_valve_open;
    logic [1:0]            button_light;
    logic                  low_power;
  } rss_out_t;

  typedef struct packed {
    logic [TimerWidth-1:0] low_power_delay;
    logic [TimerWidth-1:0] prewash_time;
    logic [TimerWidth-1:0] flow_stop_time;
    logic [TimerWidth-1:0] airgap_time;
    logic [TimerWidth-1:0] postwash_time;
    logic [TimerWidth-1:0] final_empty_time;
    logic [DelayWidth-1:0] first_loop_delay;
    logic [DelayWidth-1:0] resume_loop_delay;
  } rss_cfg_t;

  // Sequencer state, including the held actuator outputs.
  typedef struct packed {
    phase_e                phase;
    logic [TimerWidth-1:0] phase_timer;
    logic [TimerWidth-1:0] low_power_timer;
    logic [TimerWidth-1:0] recent_timer;
    logic                  low_power_flag;
    logic                  shower_recorded;
    logic                  loop_armed;
    logic                  fresh_shower;
    logic                  resumed;
    logic                  button_latch;
    logic                  emergency_latch;
    logic                  dp_run;
    logic [PowerWidth-1:0] dp_level;
    logic                  lp_run;
    logic                  lamp;
    logic [4:0]            valves;
    light_e                light;
  } rss_state_t;

  // State plus the phase requested by the rule just run.
  typedef struct packed {
    rss_state_t st;
    phase_e     nxt;
  } rss_work_t;

endpackage

@@ src/recirculating_shower_sequencer.sv @@
// Recirculating shower sequencer: eight-phase pump and valve controller, one item per tick.
//
// Each input item is one controller tick (knob, lamp feedback, loop button, emergency).
// The block takes one item per clock cycle while results are taken, and returns exactly one
// result item for it: the item is captured in an input register, the whole tick
// (latches, timers, the current phase's rule, the emergency override and up to two
// chained phase entries, e.g. pre-backwash -> shower -> loop) is worked out in one short
// combinational pass, and the new state and result land together in the state and result
// registers. The rate of one item a cycle is set by that state feedback loop. A waiting
// result does not block the input register, and in_ready_o only drops when both the input
// and result registers are full and the result is not taken. Configuration writes are
// taken at any time (cfg_ready_o is always high) and must only be issued while no item is
// in flight. Out of reset the block sits in idle with all valves open, pumps and lamp off.
module recirculating_shower_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rss_pkg::rss_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rss_pkg::rss_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [19:0]      cfg_data_i
);
  import rss_pkg::*;

  localparam rss_state_t StateReset = '{
    phase:           PH_IDLE,
    phase_timer:     '0,
    low_power_timer: '0,
    recent_timer:    '0,
    low_power_flag:  1'b1,
    shower_recorded: 1'b0,
    loop_armed:      1'b1,
    fresh_shower:    1'b1,
    resumed:         1'b0,
    button_latch:    1'b0,
    emergency_latch: 1'b0,
    dp_run:          1'b0,
    dp_level:        '0,
    lp_run:          1'b0,
    lamp:            1'b0,
    valves:          5'h1F,
    light:           LIGHT_STEADY
  };

  rss_cfg_t   cfg_q;
  rss_state_t st_q;
  rss_in_t    in_q;
  logic       in_valid_q;
  rss_out_t   out_q, out_d;
  logic       out_valid_q;
  logic       adv_s;
  rss_work_t  work_s;

  // ---------------------------------------------------------------------------
  // Tick rule helpers
  // ---------------------------------------------------------------------------

  function automatic logic [PowerWidth-1:0] clamp_power(logic [PowerWidth-1:0] p);
    return (p > FullPower) ? FullPower : p;
  endfunction

  function automatic logic [TimerWidth-1:0] sat_inc(logic [TimerWidth-1:0] t);
    return (t == TimerMax) ? t : t + TimerWidth'(1);
  endfunction

  // Knob drives diverter and pump level; knob off requests flow stop.
  function automatic rss_work_t shower_body(rss_work_t w, rss_in_t k, rss_cfg_t c);
    logic                  early;
    logic [TimerWidth-1:0] lim;
    if (k.head_on || k.hand_on) begin
      if (k.head_on) begin
        w.st.valves[0] = 1'b0;
        w.st.dp_level  = clamp_power(k.head_power);
      end else begin
        w.st.valves[0] = 1'b1;
        w.st.dp_level  = clamp_power(k.hand_power);
      end
      if (k.lamp_feedback) begin
        early = w.st.fresh_shower || w.st.resumed;
        if (w.st.button_latch) begin
          if (early) begin
            w.st.loop_armed = !w.st.loop_armed;
            w.st.light      = w.st.loop_armed ? LIGHT_FLASH : LIGHT_STEADY;
          end else begin
            w.st.loop_armed = 1'b1;
            w.nxt           = PH_LOOP;
          end
          w.st.button_latch = 1'b0;
        end
        lim = w.st.resumed ? TimerWidth'(c.resume_loop_delay)
                           : TimerWidth'(c.first_loop_delay);
        if (early && w.st.loop_armed && (w.st.phase_timer >= lim)) begin
          w.st.fresh_shower = 1'b0;
          w.nxt             = PH_LOOP;
        end
      end
    end else begin
      w.nxt = PH_STOP;
    end
    return w;
  endfunction

  function automatic rss_work_t loop_body(rss_work_t w, rss_in_t k);
    if (k.head_on || k.hand_on) begin
      if (k.head_on) begin
        w.st.valves[0] = 1'b0;
        w.st.dp_level  = clamp_power(k.head_power);
      end else begin
        w.st.valves[0] = 1'b1;
        w.st.dp_level  = clamp_power(k.hand_power);
      end
      if (!k.lamp_feedback || w.st.button_latch) begin
        w.st.button_latch = 1'b0;
        w.st.loop_armed   = 1'b0;
        w.nxt             = PH_SHOWER;
      end
    end else begin
      w.nxt = PH_STOP;
    end
    return w;
  endfunction

  // Cleaning phases: knob back on resumes the shower, else run out the timer.
  function automatic rss_work_t cleaning_tick(rss_work_t w, rss_in_t k,
                                              logic [TimerWidth-1:0] lim, phase_e after);
    if (k.head_on || k.hand_on) begin
      w.st.resumed = 1'b1;
      w.nxt        = PH_SHOWER;
    end else if (w.st.phase_timer >= lim) begin
      w.nxt = after;
    end
    return w;
  endfunction

  function automatic rss_work_t tick_rule(rss_work_t w, rss_in_t k, rss_cfg_t c);
    case (w.st.phase)
      PH_IDLE: begin
        if (!w.st.low_power_flag &&
            ((w.st.low_power_timer >= c.low_power_delay) || w.st.emergency_latch)) begin
          w.st.low_power_flag = 1'b1;
          w.st.lamp           = 1'b0;
        end
        if (!w.st.emergency_latch && (k.head_on || k.hand_on)) begin
          if (!w.st.shower_recorded || (w.st.recent_timer >= RecentShowerTicks)) begin
            w.nxt = PH_PRE;
          end else begin
            w.st.fresh_shower = 1'b1;
            w.st.loop_armed   = 1'b1;
            w.nxt             = PH_SHOWER;
          end
        end
      end
      PH_PRE: begin
        if (w.st.phase_timer >= c.prewash_time) begin
          w.st.fresh_shower = 1'b1;
          w.st.loop_armed   = 1'b1;
          w.nxt             = PH_SHOWER;
        end
      end
      PH_SHOWER: w = shower_body(w, k, c);
      PH_LOOP:   w = loop_body(w, k);
      PH_STOP:   w = cleaning_tick(w, k, c.flow_stop_time, PH_AIRGAP);
      PH_AIRGAP: w = cleaning_tick(w, k, c.airgap_time, PH_POST);
      PH_POST:   w = cleaning_tick(w, k, c.postwash_time, PH_FINAL);
      default:   w = cleaning_tick(w, k, c.final_empty_time, PH_IDLE);
    endcase
    return w;
  endfunction

  // Entry action of phase w.st.phase: actuator tables, then the phase's own work.
  function automatic rss_work_t enter_phase(rss_work_t w, rss_in_t k, rss_cfg_t c);
    phase_e     p;
    logic [4:0] upd;
    p   = w.st.phase;
    upd = ValveUpd[p];
    if (p == PH_PRE || p == PH_SHOWER) w.st.lamp = 1'b1;
    w.st.lp_run      = (p == PH_LOOP);
    w.st.dp_run      = (p == PH_PRE) || (p == PH_SHOWER) || (p == PH_LOOP) ||
                       (p == PH_AIRGAP) || (p == PH_POST);
    w.st.valves      = (w.st.valves & ~upd) | (ValveVal[p] & upd);
    w.st.light       = (p == PH_LOOP) ? LIGHT_DARK : LIGHT_STEADY;
    w.st.phase_timer = '0;
    case (p)
      PH_IDLE: begin
        w.st.low_power_flag  = 1'b0;
        w.st.low_power_timer = '0;
        w.st.shower_recorded = 1'b1;
        w.st.recent_timer    = '0;
      end
      PH_PRE, PH_AIRGAP: w.st.dp_level = FullPower;
      PH_SHOWER: begin
        if (w.st.loop_armed && (w.st.fresh_shower || w.st.resumed)) w.st.light = LIGHT_FLASH;
        w = shower_body(w, k, c);
      end
      PH_LOOP: w = loop_body(w, k);
      default: ;
    endcase
    return w;
  endfunction

  // One transition if one is pending; leaving the shower ends a resumed session.
  function automatic rss_work_t step_phase(rss_work_t w, rss_in_t k, rss_cfg_t c);
    if (w.nxt != w.st.phase) begin
      if (w.st.phase == PH_SHOWER) w.st.resumed = 1'b0;
      w.st.phase = w.nxt;
      w = enter_phase(w, k, c);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------

  // The item in the input register is processed when the result register is free or being read.
  assign adv_s       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv_s;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // One tick. A tick chains at most two entries: a phase entering the shower may
  // leave for loop (button or zero delay) or flow stop (knob off); loop and flow
  // stop then have nothing further to do with the same inputs.
  // ---------------------------------------------------------------------------

  always_comb begin
    work_s.st = st_q;
    if (in_q.loop_press) work_s.st.button_latch = 1'b1;
    if (in_q.emergency)  work_s.st.emergency_latch = 1'b1;
    work_s.st.phase_timer     = sat_inc(st_q.phase_timer);
    work_s.st.low_power_timer = sat_inc(st_q.low_power_timer);
    work_s.st.recent_timer    = sat_inc(st_q.recent_timer);
    work_s.nxt = st_q.phase;
    work_s = tick_rule(work_s, in_q, cfg_q);
    if (work_s.st.emergency_latch) work_s.nxt = PH_IDLE;
    work_s = step_phase(work_s, in_q, cfg_q);
    work_s = step_phase(work_s, in_q, cfg_q);
  end

  always_comb begin
    out_d.phase               = 3'(work_s.st.phase);
    out_d.delivery_pump_run   = work_s.st.dp_run;
    out_d.delivery_pump_level = work_s.st.dp_level;
    out_d.loop_pump_run       = work_s.st.lp_run;
    out_d.lamp_drive          = work_s.st.lamp;
    out_d.diverter_open       = work_s.st.valves[0];
    out_d.head_drain_open     = work_s.st.valves[1];
    out_d.delivery_drain_open = work_s.st.valves[2];
    out_d.loop_drain_open     = work_s.st.valves[3];
    out_d.relay_valve_open    = work_s.st.valves[4];
    out_d.button_light        = 2'(work_s.st.light);
    out_d.low_power           = work_s.st.low_power_flag && (work_s.st.phase == PH_IDLE);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= StateReset;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (adv_s) begin
        out_valid_q <= 1'b1;
        st_q        <= work_s.st;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (adv_s) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_power_delay   <= 20'd3000;
      cfg_q.prewash_time      <= 20'd150;
      cfg_q.flow_stop_time    <= 20'd1200;
      cfg_q.airgap_time       <= 20'd100;
      cfg_q.postwash_time     <= 20'd80;
      cfg_q.final_empty_time  <= 20'd120;
      cfg_q.first_loop_delay  <= 10'd300;
      cfg_q.resume_loop_delay <= 10'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LOW_POWER_DELAY:   cfg_q.low_power_delay   <= cfg_data_i;
        CFG_PREWASH_TIME:      cfg_q.prewash_time      <= cfg_data_i;
        CFG_FLOW_STOP_TIME:    cfg_q.flow_stop_time    <= cfg_data_i;
        CFG_AIRGAP_TIME:       cfg_q.airgap_time       <= cfg_data_i;
        CFG_POSTWASH_TIME:     cfg_q.postwash_time     <= cfg_data_i;
        CFG_FINAL_EMPTY_TIME:  cfg_q.final_empty_time  <= cfg_data_i;
        CFG_FIRST_LOOP_DELAY:  cfg_q.first_loop_delay  <= cfg_data_i[DelayWidth-1:0];
        CFG_RESUME_LOOP_DELAY: cfg_q.resume_loop_delay <= cfg_data_i[DelayWidth-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Two chained entries always settle the tick.
  chain_settles_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_s |-> (work_s.nxt == work_s.st.phase))
    else $error("phase chain did not settle within two entries");

  // A latched emergency leaves the block in idle after the next tick.
  emergency_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_s && (st_q.emergency_latch || in_q.emergency)) |=> (st_q.phase == PH_IDLE))
    else $error("emergency did not force idle");

  // Loop pump runs exactly in the loop phase.
  loop_pump_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.lp_run == (st_q.phase == PH_LOOP))
    else $error("loop pump out of step with phase");

  // Sequencer state moves only with a processed item.
  state_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_s |=> $stable(st_q))
    else $error("state changed without an item");

endmodule

@@ verif/testbench.sv @@
// Testbench for the recirculating shower sequencer: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module testbench;
  import rss_pkg::*;

  // Extra wait that lets the block settle before a register write or the end of the run.
  localparam int unsigned SettleCycles = 6;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int unsigned HangLimit = 4000;
  // Our own copies of the fixed numbers, so the package values are checked too.
  localparam logic [9:0]  FullLevel   = 10'd1000;
  localparam logic [19:0] RecentTicks = 20'd0;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  rss_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rss_out_t out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i  = '0;

  recirculating_shower_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial forever #2 clk_i = ~clk_i;

  // Idling percentages: chance per cycle that the sender holds back or the
  // receiver stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;

  // Actuator states predicted for every accepted tick, oldest first.
  rss_out_t tick_outputs_q [$];

  // ---------------------------------------------------------------------------
  // Predicted controller: timing registers, phase, timers, flags and held outputs.
  // ---------------------------------------------------------------------------
  logic [19:0] cfg_regs [8];
  phase_e      cur_phase, req_phase;
  logic [19:0] t_phase, t_idle, t_recent;
  logic        idle_lp, had_shower, loop_on, first_run, resumed_run;
  logic        btn_held, estop_held;
  logic        pump_fwd, loop_fwd, uv_on;
  logic [9:0]  pump_level;
  logic [4:0]  valve_bits;  // 0 diverter, 1 head drain, 2 delivery drain, 3 loop drain, 4 relay
  logic [1:0]  led;
  rss_in_t     knob;        // inputs of the tick being worked out

  function automatic void sequencer_reset();
    cfg_regs[CFG_LOW_POWER_DELAY]   = 20'd3000;
    cfg_regs[CFG_PREWASH_TIME]      = 20'd150;
    cfg_regs[CFG_FLOW_STOP_TIME]    = 20'd1200;
    cfg_regs[CFG_AIRGAP_TIME]       = 20'd100;
    cfg_regs[CFG_POSTWASH_TIME]     = 20'd80;
    cfg_regs[CFG_FINAL_EMPTY_TIME]  = 20'd120;
    cfg_regs[CFG_FIRST_LOOP_DELAY]  = 20'd300;
    cfg_regs[CFG_RESUME_LOOP_DELAY] = 20'd100;
    cur_phase   = PH_IDLE;
    req_phase   = PH_IDLE;
    t_phase     = '0;
    t_idle      = '0;
    t_recent    = '0;
    idle_lp     = 1'b1;
    had_shower  = 1'b0;
    loop_on     = 1'b1;
    first_run   = 1'b1;
    resumed_run = 1'b0;
    btn_held    = 1'b0;
    estop_held  = 1'b0;
    pump_fwd    = 1'b0;
    loop_fwd    = 1'b0;
    uv_on       = 1'b0;
    pump_level  = '0;
    valve_bits  = 5'h1F;
    led         = LIGHT_STEADY;
  endfunction

  function automatic logic [9:0] power_limit(logic [9:0] p);
    return (p > FullLevel) ? FullLevel : p;
  endfunction

  // Head has priority over hand; knob off asks for flow stop.
  function automatic logic follow_knob();
    if (knob.head_on) begin
      valve_bits[0] = 1'b0;
      pump_level    = power_limit(knob.head_power);
    end else if (knob.hand_on) begin
      valve_bits[0] = 1'b1;
      pump_level    = power_limit(knob.hand_power);
    end else begin
      req_phase = PH_STOP;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void shower_tick();
    logic        early;
    logic [19:0] limit;
    if (!follow_knob()) return;
    if (!knob.lamp_feedback) return;
    // "early" is taken once, before the button may flip the arming
    early = first_run || resumed_run;
    if (btn_held) begin
      if (early) begin
        loop_on = !loop_on;
        led     = loop_on ? LIGHT_FLASH : LIGHT_STEADY;
      end else begin
        loop_on   = 1'b1;
        req_phase = PH_LOOP;
      end
      btn_held = 1'b0;
    end
    if (early && loop_on) begin
      limit = resumed_run ? cfg_regs[CFG_RESUME_LOOP_DELAY] : cfg_regs[CFG_FIRST_LOOP_DELAY];
      if (t_phase >= limit) begin
        first_run = 1'b0;
        req_phase = PH_LOOP;
      end
    end
  endfunction

  function automatic void loop_tick();
    if (!follow_knob()) return;
    if (!knob.lamp_feedback || btn_held) begin
      btn_held  = 1'b0;
      loop_on   = 1'b0;
      req_phase = PH_SHOWER;
    end
  endfunction

  // Cleaning phases: knob on resumes the shower, otherwise wait out the timer.
  function automatic void cleaning_tick(logic [19:0] limit, phase_e after);
    if (knob.head_on || knob.hand_on) begin
      resumed_run = 1'b1;
      req_phase   = PH_SHOWER;
    end else if (t_phase >= limit) begin
      req_phase = after;
    end
  endfunction

  function automatic void phase_enter(phase_e p);
    if (p == PH_PRE || p == PH_SHOWER) uv_on = 1'b1;
    loop_fwd = (p == PH_LOOP);
    pump_fwd = (p == PH_PRE) || (p == PH_SHOWER) || (p == PH_LOOP) ||
               (p == PH_AIRGAP) || (p == PH_POST);
    // valve entry table; bits not listed keep their value
    case (p)
      PH_IDLE:             valve_bits = 5'h1F;
      PH_PRE:              valve_bits = 5'b01101;
      PH_SHOWER, PH_LOOP:  valve_bits = {4'b0001, valve_bits[0]};
      PH_STOP:             valve_bits = {valve_bits[4], 3'b001, valve_bits[0]};
      PH_AIRGAP, PH_POST:  valve_bits = {valve_bits[4], 4'b1101};
      default:             valve_bits = {valve_bits[4], 4'b1111};
    endcase
    led     = (p == PH_LOOP) ? LIGHT_DARK : LIGHT_STEADY;
    t_phase = '0;
    case (p)
      PH_IDLE: begin
        idle_lp    = 1'b0;
        t_idle     = '0;
        had_shower = 1'b1;
        t_recent   = '0;
      end
      PH_PRE, PH_AIRGAP: pump_level = FullLevel;
      PH_SHOWER: begin
        if (loop_on && (first_run || resumed_run)) led = LIGHT_FLASH;
        shower_tick();
      end
      PH_LOOP: loop_tick();
      default: ;
    endcase
  endfunction

  // One controller tick: latches, timers, phase rule, emergency override,
  // then the chain of phase entries.
  function automatic rss_out_t sequencer_tick(rss_in_t tick_in);
    int       hops;
    rss_out_t r;
    knob = tick_in;
    if (tick_in.loop_press) btn_held = 1'b1;
    if (tick_in.emergency) estop_held = 1'b1;
    if (t_phase != '1) t_phase++;
    if (t_idle != '1) t_idle++;
    if (t_recent != '1) t_recent++;
    req_phase = cur_phase;
    case (cur_phase)
      PH_IDLE: begin
        if (!idle_lp && (t_idle >= cfg_regs[CFG_LOW_POWER_DELAY] || estop_held)) begin
          idle_lp = 1'b1;
          uv_on   = 1'b0;
        end
        if (!estop_held && (knob.head_on || knob.hand_on)) begin
          if (!had_shower || t_recent >= RecentTicks) begin
            req_phase = PH_PRE;
          end else begin
            first_run = 1'b1;
            loop_on   = 1'b1;
            req_phase = PH_SHOWER;
          end
        end
      end
      PH_PRE: begin
        if (t_phase >= cfg_regs[CFG_PREWASH_TIME]) begin
          first_run = 1'b1;
          loop_on   = 1'b1;
          req_phase = PH_SHOWER;
        end
      end
      PH_SHOWER: shower_tick();
      PH_LOOP:   loop_tick();
      PH_STOP:   cleaning_tick(cfg_regs[CFG_FLOW_STOP_TIME], PH_AIRGAP);
      PH_AIRGAP: cleaning_tick(cfg_regs[CFG_AIRGAP_TIME], PH_POST);
      PH_POST:   cleaning_tick(cfg_regs[CFG_POSTWASH_TIME], PH_FINAL);
      default:   cleaning_tick(cfg_regs[CFG_FINAL_EMPTY_TIME], PH_IDLE);
    endcase
    if (estop_held) req_phase = PH_IDLE;
    hops = 0;
    while (cur_phase != req_phase && hops < 16) begin
      if (cur_phase == PH_SHOWER) resumed_run = 1'b0;  // leaving the shower
      cur_phase = req_phase;
      phase_enter(cur_phase);
      hops++;
    end
    r.phase               = cur_phase;
    r.delivery_pump_run   = pump_fwd;
    r.delivery_pump_level = pump_level;
    r.loop_pump_run       = loop_fwd;
    r.lamp_drive          = uv_on;
    r.diverter_open       = valve_bits[0];
    r.head_drain_open     = valve_bits[1];
    r.delivery_drain_open = valve_bits[2];
    r.loop_drain_open     = valve_bits[3];
    r.relay_valve_open    = valve_bits[4];
    r.button_light        = led;
    r.low_power           = idle_lp && (cur_phase == PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and the hang watchdog
  // ---------------------------------------------------------------------------
  function automatic void field_check(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("tick %0d, %s: expected 0x%0h, got 0x%0h", results_seen, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    rss_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tick_outputs_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("output item with no tick waiting: %h", out_data_o);
      end else begin
        want = tick_outputs_q.pop_front();
        field_check("phase", 32'(want.phase), 32'(out_data_o.phase));
        field_check("delivery_pump_run", 32'(want.delivery_pump_run),
                    32'(out_data_o.delivery_pump_run));
        field_check("delivery_pump_level", 32'(want.delivery_pump_level),
                    32'(out_data_o.delivery_pump_level));
        field_check("loop_pump_run", 32'(want.loop_pump_run), 32'(out_data_o.loop_pump_run));
        field_check("lamp_drive", 32'(want.lamp_drive), 32'(out_data_o.lamp_drive));
        field_check("diverter_open", 32'(want.diverter_open), 32'(out_data_o.diverter_open));
        field_check("head_drain_open", 32'(want.head_drain_open),
                    32'(out_data_o.head_drain_open));
        field_check("delivery_drain_open", 32'(want.delivery_drain_open),
                    32'(out_data_o.delivery_drain_open));
        field_check("loop_drain_open", 32'(want.loop_drain_open),
                    32'(out_data_o.loop_drain_open));
        field_check("relay_valve_open", 32'(want.relay_valve_open),
                    32'(out_data_o.relay_valve_open));
        field_check("button_light", 32'(want.button_light), 32'(out_data_o.button_light));
        field_check("low_power", 32'(want.low_power), 32'(out_data_o.low_power));
      end
      results_seen++;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < HangLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic rss_in_t knob_tick(logic head, logic hand, logic [9:0] hp,
                                        logic [9:0] hap, logic lamp, logic press);
    rss_in_t t;
    t = '0;
    t.head_on       = head;
    t.hand_on       = hand;
    t.head_power    = hp;
    t.hand_power    = hap;
    t.lamp_feedback = lamp;
    t.loop_press    = press;
    return t;
  endfunction

  // Mostly legal per-mille values, now and then above full power.
  function automatic logic [9:0] rand_power();
    return ($urandom_range(7) == 0) ? 10'($urandom_range(1000, 1023))
                                    : 10'($urandom_range(0, 1000));
  endfunction

  // Fully random tick, emergency kept clear.
  function automatic rss_in_t rand_tick();
    rss_in_t t;
    t = rss_in_t'($urandom);
    t.emergency = 1'b0;
    return t;
  endfunction

  task automatic set_idling(int unsigned send_gap, int unsigned recv_stall);
    gap_pct   = send_gap;
    stall_pct = recv_stall;
  endtask

  // Offer one tick; valid stays up until taken. The prediction is made on acceptance.
  task automatic send_tick(rss_in_t tick_in);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= tick_in;
    do @(posedge clk_i); while (!in_ready_o);
    tick_outputs_q.push_back(sequencer_tick(tick_in));
    items_sent++;
  endtask

  // Stop offering ticks and let every outstanding result come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tick_outputs_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Only called with nothing in flight.
  task automatic cfg_write(cfg_idx_e idx, logic [19:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    // the two loop delays are 10 bits wide, upper bits dropped
    if (idx == CFG_FIRST_LOOP_DELAY || idx == CFG_RESUME_LOOP_DELAY)
      cfg_regs[idx] = {10'd0, value[9:0]};
    else
      cfg_regs[idx] = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write every register with a value drawn from [lo, hi].
  task automatic cfg_load(int unsigned lo, int unsigned hi);
    wait_drained();
    for (int i = 0; i < 8; i++) cfg_write(cfg_idx_e'(i), 20'($urandom_range(lo, hi)));
  endtask

  // A realistic session: knob on for a while (button and lamp noise), then off
  // long enough to run some or all of the cleaning sequence. A following
  // session often lands in a cleaning phase and resumes the shower.
  task automatic shower_session();
    int unsigned on_len, off_len;
    logic        head, hand;
    logic [9:0]  hp, hap;
    on_len  = $urandom_range(1, 25);
    off_len = $urandom_range(1, 20);
    head    = 1'($urandom_range(1));
    hand    = head ? 1'($urandom_range(1)) : 1'b1;
    hp      = rand_power();
    hap     = rand_power();
    repeat (on_len) begin
      if ($urandom_range(15) == 0) begin
        // knob moved between head and hand
        head = !head;
        hand = !head ? 1'b1 : 1'($urandom_range(1));
        hp   = rand_power();
        hap  = rand_power();
      end
      send_tick(knob_tick(head, hand, hp, hap, $urandom_range(9) != 0,
                          $urandom_range(7) == 0));
    end
    repeat (off_len)
      send_tick(knob_tick(1'b0, 1'b0, 10'($urandom), 10'($urandom), 1'($urandom_range(1)),
                          $urandom_range(9) == 0));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    // idle, low power from reset, entry actions not yet run
    send_tick(knob_tick(1'b0, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0));
    send_tick(knob_tick(1'b0, 1'b0, 10'h3FF, 10'h3FF, 1'b1, 1'b0));
  endtask

  task automatic test_register_writes();
    wait_drained();
    cfg_write(CFG_LOW_POWER_DELAY, 20'd2);
    cfg_write(CFG_PREWASH_TIME, 20'd1);
    cfg_write(CFG_FLOW_STOP_TIME, 20'd1);
    cfg_write(CFG_AIRGAP_TIME, 20'd1);
    cfg_write(CFG_POSTWASH_TIME, 20'd1);
    cfg_write(CFG_FINAL_EMPTY_TIME, 20'd1);
    // upper bits set on the short registers: only the low ten count
    cfg_write(CFG_FIRST_LOOP_DELAY, 20'hFFC03);
    cfg_write(CFG_RESUME_LOOP_DELAY, 20'hFFC01);
  endtask

  task automatic test_knob_selection();
    // start: pre-backwash at full power, then into the shower
    send_tick(knob_tick(1'b1, 1'b1, 10'h3FF, 10'd0, 1'b1, 1'b0));
    // head power above full power saturates
    send_tick(knob_tick(1'b1, 1'b1, 10'h3FF, 10'd0, 1'b1, 1'b0));
    // hand only: diverter opens
    send_tick(knob_tick(1'b0, 1'b1, 10'd0, 10'd1000, 1'b1, 1'b0));
    // both on: head wins, zero power
    send_tick(knob_tick(1'b1, 1'b1, 10'd0, 10'h3FF, 1'b1, 1'b0));
  endtask

  task automatic test_loop_button();
    // fresh shower: button toggles the arming off, then on again, then auto loop
    send_tick(knob_tick(1'b0, 1'b1, 10'd0, 10'd517, 1'b1, 1'b1));
    send_tick(knob_tick(1'b0, 1'b1, 10'd0, 10'd517, 1'b1, 1'b1));
    // lamp dark in loop drops back to shower
    send_tick(knob_tick(1'b0, 1'b1, 10'd0, 10'd517, 1'b0, 1'b0));
    // settled shower: button goes straight to loop, and back out again
    send_tick(knob_tick(1'b1, 1'b0, 10'd800, 10'd0, 1'b1, 1'b1));
    send_tick(knob_tick(1'b1, 1'b0, 10'd800, 10'd0, 1'b1, 1'b1));
  endtask

  task automatic test_cleaning_resume();
    // knob off: flow stop, button pressed where nobody reads it
    send_tick(knob_tick(1'b0, 1'b0, 10'd0, 10'd0, 1'b1, 1'b0));
    send_tick(knob_tick(1'b0, 1'b0, 10'd0, 10'd0, 1'b1, 1'b1));
    // knob on from the airgap: resumed shower picks up the held button
    send_tick(knob_tick(1'b1, 1'b0, 10'd600, 10'd0, 1'b1, 1'b0));
    send_tick(knob_tick(1'b1, 1'b0, 10'd600, 10'd0, 1'b1, 1'b0));
    // run down to post-backwash, then turn the knob on there
    repeat (3) send_tick(knob_tick(1'b0, 1'b0, 10'd0, 10'd0, 1'b1, 1'b0));
    send_tick(knob_tick(1'b0, 1'b1, 10'd0, 10'd1, 1'b1, 1'b0));
    // full cleaning run to idle, then into low power
    repeat (7) send_tick(knob_tick(1'b0, 1'b0, 10'd0, 10'd0, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic(int unsigned n_ticks);
    int unsigned stop_at;
    stop_at = items_sent + n_ticks;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 85)
        shower_session();
      else
        repeat ($urandom_range(1, 8)) send_tick(rand_tick());
    end
  endtask

  // Last test: the emergency latch only clears on reset.
  task automatic test_emergency_stop();
    rss_in_t t;
    repeat (3) send_tick(knob_tick(1'b1, 1'b0, rand_power(), rand_power(), 1'b1, 1'b0));
    t = knob_tick(1'b1, 1'b1, 10'd1000, 10'd1000, 1'b1, 1'b1);
    t.emergency = 1'b1;
    send_tick(t);
    repeat (8) begin
      t = rand_tick();
      t.emergency = 1'($urandom_range(1));
      send_tick(t);
    end
  endtask

  initial begin
    sequencer_reset();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idling(10, 86);
    test_reset_state();
    test_register_writes();
    test_knob_selection();
    test_loop_button();
    test_cleaning_resume();

    cfg_load(0, 8);
    test_random_traffic(200);

    set_idling(86, 10);
    cfg_load(0, 0);  // zero timers: phases chain within one tick
    test_random_traffic(150);

    set_idling(0, 0);
    cfg_load(0, 8);
    test_random_traffic(150);
    cfg_load(20'hFFFFF, 20'hFFFFF);  // nothing times out, only the knob moves on
    test_random_traffic(100);

    test_emergency_stop();
    wait_drained();

    if (mismatch_count == 0 && tick_outputs_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ recirculating_shower_sequencer.f @@
src/rss_pkg.sv
src/recirculating_shower_sequencer.sv
verif/testbench.sv
